// File: hdl/bpfs_pkg.sv
package bpfs_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DIR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_DIFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_SPEC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHININESS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY   = 3'd7;

  // 1.0 in Q1.14
  localparam int UNIT_Q14 = 16384;

  // vector widths into the normalizers
  localparam int NORM_N_W = 16;
  localparam int NORM_V_W = 21;
  localparam int NORM_H_W = 17;

  // power unit depth: setup, 16 log squarings, scale, 16 exp factors, round
  localparam int POW_LAT = 35;

  // sideband that rides from input to the color stages
  typedef struct packed {
    logic [2:0][15:0] base;
    logic [31:0]      scale;
  } side_t;

  // diffuse weight and specular enable
  typedef struct packed {
    logic        en;
    logic [16:0] kd;
  } kd_t;

  // normalizer stages: square, sum, w+9 root steps, setup, 15 divide, sign
  function automatic int norm_lat(input int w);
    return w + 28;
  endfunction

  // clamp a Q.28 dot product to a Q1.14 unit value
  function automatic logic [14:0] clamp_unit(input logic signed [33:0] d);
    logic [33:0] t;
    logic [19:0] q;
    t = 34'(d) + 34'd8192;
    q = t[33:14];
    if (d <= 34'sd0) begin
      return 15'd0;
    end else if (q > 20'(UNIT_Q14)) begin
      return 15'(UNIT_Q14);
    end else begin
      return q[14:0];
    end
  endfunction

  // integer square root, used for table constants
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = x;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Q.30 factor 2^(-2^-i)
  function automatic logic [30:0] exp_factor(input int i);
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int j = 1; j <= i; j++) begin
      t = isqrt64(t << 30);
    end
    return t[30:0];
  endfunction

endpackage

// File: hdl/bpfs_norm.sv
module bpfs_norm import bpfs_pkg::*; #(
  parameter int W = 16
) (
  input  logic               clk,
  input  logic [2:0][W-1:0]  vec_in,
  output logic [2:0][15:0]   vec_out
);

  localparam int XW = 2 * W + 18;
  localparam int HI = XW / 2;
  localparam int DW = W + 25;
  localparam int QB = 15;

  logic [2:0][W-1:0]   mag_in;
  logic [2:0][W-1:0]   mag_a;
  logic [2:0]          neg_a;
  logic [2:0][2*W-1:0] sq_a;

  logic [XW-1:0]       rem_s [HI+1];
  logic [XW-1:0]       res_s [HI+1];
  logic [2:0][W-1:0]   mg_s  [HI+1];
  logic [2:0]          ng_s  [HI+1];

  logic [HI-1:0]       s_root;
  logic [2:0][DW-1:0]  num;

  logic [2:0][DW-1:0]  dv_rem [QB+1];
  logic [2:0][QB-1:0]  dv_q   [QB+1];
  logic [HI-1:0]       dv_s   [QB+1];
  logic [2:0]          dv_sat [QB+1];
  logic                dv_zero[QB+1];
  logic [2:0]          dv_neg [QB+1];

  logic [2:0][15:0]    qclamp;

  // magnitudes of the components
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_in[j] = vec_in[j][W-1] ? W'(-vec_in[j]) : vec_in[j];
    end
  end

  // squares
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      neg_a[j] <= vec_in[j][W-1];
      mag_a[j] <= mag_in[j];
      sq_a[j]  <= (2*W)'(mag_in[j]) * (2*W)'(mag_in[j]);
    end
  end

  // squared length scaled by 2^16
  always_ff @(posedge clk) begin
    rem_s[0] <= (XW'(sq_a[0]) + XW'(sq_a[1]) + XW'(sq_a[2])) << 16;
    res_s[0] <= '0;
    mg_s[0]  <= mag_a;
    ng_s[0]  <= neg_a;
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < HI; i++) begin : g_root
    localparam logic [XW:0] BIT = (XW+1)'(1) << (XW - 2 - 2 * i);
    logic [XW:0] trial;
    assign trial = {1'b0, res_s[i]} + BIT;
    always_ff @(posedge clk) begin
      if ({1'b0, rem_s[i]} >= trial) begin
        rem_s[i+1] <= XW'({1'b0, rem_s[i]} - trial);
        res_s[i+1] <= XW'(({1'b0, res_s[i]} >> 1) + BIT);
      end else begin
        rem_s[i+1] <= rem_s[i];
        res_s[i+1] <= res_s[i] >> 1;
      end
      mg_s[i+1] <= mg_s[i];
      ng_s[i+1] <= ng_s[i];
    end
  end

  assign s_root = res_s[HI][HI-1:0];

  // rounded dividends and overflow check
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = (DW'(mg_s[HI][j]) << 22) + DW'(s_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dv_rem[0][j] <= num[j];
      dv_q[0][j]   <= '0;
      dv_sat[0][j] <= num[j] >= (DW'(s_root) << QB);
    end
    dv_s[0]    <= s_root;
    dv_zero[0] <= s_root == '0;
    dv_neg[0]  <= ng_s[HI];
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [2:0][DW-1:0] trial;
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = DW'(dv_s[k]) << B;
      end
    end
    always_ff @(posedge clk) begin
      for (int j = 0; j < 3; j++) begin
        if (!dv_sat[k][j] && dv_rem[k][j] >= trial[j]) begin
          dv_rem[k+1][j] <= dv_rem[k][j] - trial[j];
          dv_q[k+1][j]   <= dv_q[k][j] | (QB'(1) << B);
        end else begin
          dv_rem[k+1][j] <= dv_rem[k][j];
          dv_q[k+1][j]   <= dv_q[k][j];
        end
      end
      dv_s[k+1]    <= dv_s[k];
      dv_sat[k+1]  <= dv_sat[k];
      dv_zero[k+1] <= dv_zero[k];
      dv_neg[k+1]  <= dv_neg[k];
    end
  end

  // clamp to unit and restore sign
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qclamp[j] = dv_sat[QB][j] ? 16'd32768 : {1'b0, dv_q[QB][j]};
      if (qclamp[j] > 16'(UNIT_Q14)) begin
        qclamp[j] = 16'(UNIT_Q14);
      end
      if (dv_zero[QB]) begin
        qclamp[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      vec_out[j] <= dv_neg[QB][j] ? 16'(-qclamp[j]) : qclamp[j];
    end
  end

endmodule

// File: hdl/blinn_phong_fragment_shade.sv
// channel    | handshake           | payload
// -----------+---------------------+------------------------------------------
// request in | start, busy         | albedo_r/g/b, normal_x/y/z, pos_x/y/z,
//            |                     | visibility
// result out | done (one cycle)    | shade_r, shade_g, shade_b
// config     | cfg_we              | cfg_index, cfg_data
//
// One request per clock; busy stays low. Each result is strobed once its request has passed
// through the view normalizer (49 stages), the half vector normalizer (45 stages), the
// power unit (35 stages) and the color math.
// Synchronous active-high rst returns the configuration to its defaults and clears the valid chain.
// Results are strobed by done for one cycle and cannot be held off.
module blinn_phong_fragment_shade import bpfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [15:0]           albedo_r,
  input  logic [15:0]           albedo_g,
  input  logic [15:0]           albedo_b,
  input  logic signed [15:0]    normal_x,
  input  logic signed [15:0]    normal_y,
  input  logic signed [15:0]    normal_z,
  input  logic signed [19:0]    pos_x,
  input  logic signed [19:0]    pos_y,
  input  logic signed [19:0]    pos_z,
  input  logic [15:0]           visibility,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [15:0]           shade_r,
  output logic [15:0]           shade_g,
  output logic [15:0]           shade_b
);

  localparam int LN       = norm_lat(NORM_N_W);
  localparam int LV       = norm_lat(NORM_V_W);
  localparam int LH       = norm_lat(NORM_H_W);
  localparam int S        = 5 + LV + LH + POW_LAT;
  localparam int TOT      = S + 5;
  localparam int N_ALIGN  = LV - LN;
  localparam int N_LATE   = LH + 2;
  localparam int KD_LEN   = 2 + LH + POW_LAT;
  localparam int SIDE_LEN = S;

  // configuration
  logic [47:0] light_direction;
  logic [47:0] light_color;
  logic [47:0] material_diffuse;
  logic [47:0] material_specular;
  logic [59:0] eye_pos;
  logic [15:0] shininess;
  logic [15:0] ambient_share;
  logic [15:0] light_intensity;

  logic [TOT-1:0] vld_q;

  logic [2:0][15:0] alb0;
  logic [2:0][15:0] nrm0;
  logic [2:0][19:0] pos0;
  logic [15:0]      vis0;

  logic [2:0][15:0] nraw1;
  logic [2:0][20:0] vraw1;

  side_t side_in;
  side_t side_dly [SIDE_LEN];

  logic [2:0][15:0] n_o;
  logic [2:0][15:0] v_a;
  logic [2:0][15:0] n_al [N_ALIGN];
  logic [2:0][15:0] n_a;
  logic [2:0][15:0] n_late [N_LATE];

  logic signed [31:0] pnl [3];
  logic signed [31:0] pnv [3];
  logic [2:0][16:0]   hraw1;
  logic signed [33:0] dnl;
  logic signed [33:0] dnv;
  logic [14:0]        dnl_c;
  logic [14:0]        d2;
  logic               en2;
  logic [2:0][16:0]   h2;

  kd_t kd_in;
  kd_t kd_dly [KD_LEN];

  logic [2:0][15:0]   h_o;
  logic signed [31:0] pnh [3];
  logic [14:0]        c_reg;

  // power unit
  logic [3:0]  lead;
  logic [3:0]  k0;
  logic [30:0] pm  [17];
  logic [15:0] pf  [17];
  logic [3:0]  pk  [17];
  logic [1:0]  pfl [17];
  logic [19:0] lq;
  logic [35:0] pp;
  logic [30:0] er   [17];
  logic [15:0] efp  [17];
  logic [3:0]  eip  [17];
  logic        ebig [17];
  logic [1:0]  efl  [17];
  logic [30:0] rr;
  logic [16:0] rq;
  logic [16:0] spec_q;

  // color stages
  logic [16:0]      spec_g;
  logic [2:0][15:0] f1_dp;
  logic [2:0][15:0] f1_sp;
  side_t            f1_side;
  logic [2:0][16:0] f2_lit;
  side_t            f2_side;
  logic [48:0]      f3_m1 [3];
  logic [31:0]      f3_m2 [3];
  logic [49:0]      tot   [3];
  logic [18:0]      qo    [3];

  assign busy = 1'b0;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      light_direction   <= '0;
      light_color       <= '0;
      material_diffuse  <= '0;
      material_specular <= '0;
      eye_pos           <= '0;
      shininess         <= 16'd256;
      ambient_share     <= '0;
      light_intensity   <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_DIR:   light_direction   <= cfg_data[47:0];
        REG_LIGHT_COLOR: light_color       <= cfg_data[47:0];
        REG_MAT_DIFF:    material_diffuse  <= cfg_data[47:0];
        REG_MAT_SPEC:    material_specular <= cfg_data[47:0];
        REG_CAM_POS:     eye_pos           <= cfg_data;
        REG_SHININESS:   shininess         <= cfg_data[15:0];
        REG_AMBIENT:     ambient_share     <= cfg_data[15:0];
        REG_INTENSITY:   light_intensity   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOT-2:0], start & ~busy};
    end
  end

  assign done = vld_q[TOT-1];

  // request capture
  always_ff @(posedge clk) begin
    alb0 <= {albedo_b, albedo_g, albedo_r};
    nrm0 <= {normal_z, normal_y, normal_x};
    pos0 <= {pos_z, pos_y, pos_x};
    vis0 <= visibility;
  end

  // view vector and raw normal
  always_ff @(posedge clk) begin
    nraw1 <= nrm0;
    for (int j = 0; j < 3; j++) begin
      vraw1[j] <= 21'($signed(eye_pos[20*j +: 20])) - 21'($signed(pos0[j]));
    end
  end

  // base color and light scale
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      side_in.base[j] = 16'((32'(alb0[j]) * 32'(material_diffuse[16*j +: 16])
                             + 32'd32768) >> 16);
    end
    side_in.scale = 32'(light_intensity) * 32'(vis0);
  end

  always_ff @(posedge clk) begin
    side_dly[0] <= side_in;
    for (int i = 1; i < SIDE_LEN; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  bpfs_norm #(.W(NORM_N_W)) u_norm_n (
    .clk     (clk),
    .vec_in  (nraw1),
    .vec_out (n_o)
  );

  bpfs_norm #(.W(NORM_V_W)) u_norm_v (
    .clk     (clk),
    .vec_in  (vraw1),
    .vec_out (v_a)
  );

  // align the normal with the view vector, then hold it for the half vector
  always_ff @(posedge clk) begin
    n_al[0] <= n_o;
    for (int i = 1; i < N_ALIGN; i++) begin
      n_al[i] <= n_al[i-1];
    end
    n_late[0] <= n_a;
    for (int i = 1; i < N_LATE; i++) begin
      n_late[i] <= n_late[i-1];
    end
  end

  assign n_a = n_al[N_ALIGN-1];

  // dot products against light and view, raw half vector
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pnl[j]   <= $signed(n_a[j]) * $signed(light_direction[16*j +: 16]);
      pnv[j]   <= $signed(n_a[j]) * $signed(v_a[j]);
      hraw1[j] <= 17'($signed(light_direction[16*j +: 16])) + 17'($signed(v_a[j]));
    end
  end

  always_comb begin
    dnl   = 34'(pnl[0]) + 34'(pnl[1]) + 34'(pnl[2]);
    dnv   = 34'(pnv[0]) + 34'(pnv[1]) + 34'(pnv[2]);
    dnl_c = clamp_unit(dnl);
  end

  // lambert term and specular enable
  always_ff @(posedge clk) begin
    d2  <= dnl_c;
    en2 <= (material_specular != '0) && (dnl_c != '0) && (dnv > 34'sd0);
    h2  <= hraw1;
  end

  // diffuse weight
  always_comb begin
    kd_in.en = en2;
    kd_in.kd = 17'((33'(17'd65536 - 17'(ambient_share)) * 33'(d2) + 33'd8192) >> 14);
  end

  always_ff @(posedge clk) begin
    kd_dly[0] <= kd_in;
    for (int i = 1; i < KD_LEN; i++) begin
      kd_dly[i] <= kd_dly[i-1];
    end
  end

  bpfs_norm #(.W(NORM_H_W)) u_norm_h (
    .clk     (clk),
    .vec_in  (h2),
    .vec_out (h_o)
  );

  // specular base
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pnh[j] <= $signed(n_late[N_LATE-1][j]) * $signed(h_o[j]);
    end
    c_reg <= clamp_unit(34'(pnh[0]) + 34'(pnh[1]) + 34'(pnh[2]));
  end

  // log setup: normalize the base to a Q.30 mantissa
  always_comb begin
    lead = '0;
    for (int b = 0; b < 15; b++) begin
      if (c_reg[b]) begin
        lead = 4'(b);
      end
    end
    k0 = 4'd14 - lead;
  end

  always_ff @(posedge clk) begin
    pm[0]  <= {c_reg, 16'b0} << k0;
    pf[0]  <= '0;
    pk[0]  <= k0;
    pfl[0] <= {shininess == '0, c_reg == '0};
  end

  // log2 fraction bits by repeated squaring
  for (genvar i = 0; i < 16; i++) begin : g_log
    logic [61:0] sq;
    logic [31:0] sh;
    assign sq = 62'(pm[i]) * 62'(pm[i]);
    assign sh = sq[61:30];
    always_ff @(posedge clk) begin
      if (sh[31]) begin
        pm[i+1] <= sh[31:1];
        pf[i+1] <= {pf[i][14:0], 1'b1};
      end else begin
        pm[i+1] <= sh[30:0];
        pf[i+1] <= {pf[i][14:0], 1'b0};
      end
      pk[i+1]  <= pk[i];
      pfl[i+1] <= pfl[i];
    end
  end

  // scale the log by the exponent
  always_comb begin
    lq = 20'({pk[16], 16'b0}) - 20'(pf[16]);
    pp = (36'(lq) * 36'(shininess) + 36'd128) >> 8;
  end

  always_ff @(posedge clk) begin
    er[0]   <= 31'd1 << 30;
    efp[0]  <= pp[15:0];
    eip[0]  <= pp[19:16];
    ebig[0] <= pp[27:20] != '0;
    efl[0]  <= pfl[16];
  end

  // 2^-frac as a product of constant factors
  for (genvar g = 0; g < 16; g++) begin : g_exp
    localparam logic [30:0] EXP_T = exp_factor(g + 1);
    always_ff @(posedge clk) begin
      if (efp[g][15-g]) begin
        er[g+1] <= 31'((62'(er[g]) * 62'(EXP_T) + (62'd1 << 29)) >> 30);
      end else begin
        er[g+1] <= er[g];
      end
      efp[g+1]  <= efp[g];
      eip[g+1]  <= eip[g];
      ebig[g+1] <= ebig[g];
      efl[g+1]  <= efl[g];
    end
  end

  // integer shift and round to Q0.16
  always_comb begin
    rr = er[16] >> eip[16];
    rq = 17'((32'(rr) + 32'd8192) >> 14);
    if (rq > 17'd65536) begin
      rq = 17'd65536;
    end
  end

  always_ff @(posedge clk) begin
    priority if (efl[16][1]) begin
      spec_q <= 17'd65536;
    end else if (efl[16][0] || ebig[16]) begin
      spec_q <= '0;
    end else begin
      spec_q <= rq;
    end
  end

  // diffuse and specular parts per channel
  assign spec_g = kd_dly[KD_LEN-1].en ? spec_q : '0;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      f1_dp[j] <= 16'((33'(side_dly[SIDE_LEN-1].base[j]) * 33'(kd_dly[KD_LEN-1].kd)
                       + 33'd32768) >> 16);
      f1_sp[j] <= 16'((33'(spec_g) * 33'(material_specular[16*j +: 16])
                       + 33'd32768) >> 16);
    end
    f1_side <= side_dly[SIDE_LEN-1];
  end

  // light color
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      f2_lit[j] <= 17'((34'(light_color[16*j +: 16]) * (34'(f1_dp[j]) + 34'(f1_sp[j]))
                        + 34'd32768) >> 16);
    end
    f2_side <= f1_side;
  end

  // intensity, visibility and ambient
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      f3_m1[j] <= 49'(f2_lit[j]) * 49'(f2_side.scale);
      f3_m2[j] <= 32'(f2_side.base[j]) * 32'(ambient_share);
    end
  end

  // sum, round to Q4.12 and saturate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tot[j] = (50'(f3_m2[j]) << 11) + 50'(f3_m1[j]);
      qo[j]  = 19'((tot[j] + (50'd1 << 30)) >> 31);
    end
  end

  always_ff @(posedge clk) begin
    shade_r <= (qo[0] > 19'hFFFF) ? 16'hFFFF : qo[0][15:0];
    shade_g <= (qo[1] > 19'hFFFF) ? 16'hFFFF : qo[1][15:0];
    shade_b <= (qo[2] > 19'hFFFF) ? 16'hFFFF : qo[2][15:0];
  end

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // view normalizer output stays within unit range
  a_view_unit: assert property (@(posedge clk) disable iff (rst)
    vld_q[1+LV] |-> ($signed(v_a[0]) <= 16384 && $signed(v_a[0]) >= -16384 &&
                     $signed(v_a[1]) <= 16384 && $signed(v_a[1]) >= -16384 &&
                     $signed(v_a[2]) <= 16384 && $signed(v_a[2]) >= -16384))
    else $error("normalized view out of range");

  // power result never exceeds one
  a_pow_unit: assert property (@(posedge clk) disable iff (rst)
    vld_q[S] |-> spec_q <= 17'd65536)
    else $error("specular power above one");

  // diffuse weight never exceeds one
  a_kd_unit: assert property (@(posedge clk) disable iff (rst)
    vld_q[S] |-> kd_dly[KD_LEN-1].kd <= 17'd65536)
    else $error("diffuse weight above one");

endmodule

// File: sim/blinn_phong_fragment_shade_tb.sv
module blinn_phong_fragment_shade_tb;
  import bpfs_pkg::*;

  localparam int RAND_PHASES  = 14;
  localparam int PHASE_ITEMS  = 100;
  localparam int RESULT_LAT   = 139;
  localparam int CYCLE_LIMIT  = 600000;

  typedef longint vec3_t [3];

  typedef struct {
    logic [15:0] alb_r, alb_g, alb_b;
    logic [15:0] nx, ny, nz;
    logic [19:0] px, py, pz;
    logic [15:0] vis;
  } frag_t;

  typedef struct {
    logic [15:0] r, g, b;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] albedo_r = '0, albedo_g = '0, albedo_b = '0;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [19:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] visibility = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LIGHT_DIR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [15:0] shade_r, shade_g, shade_b;

  // fixed result for directed rows under reset settings
  logic typed_on = 1'b0;

  // shadow copy of the configuration
  logic [47:0] light_dir_q, light_col_q, mat_diff_q, mat_spec_q;
  logic [59:0] cam_pos_q;
  logic [15:0] shin_q, amb_q, inten_q;

  shade_t pending_shades[$];
  int errors = 0;
  int cycles = 0;

  blinn_phong_fragment_shade dut (.*);

  always #6 clk = ~clk;

  // integer square root
  function automatic longint unsigned sqrt_u64(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // scale a vector to Q1.14 unit length
  function automatic vec3_t unit_vec(vec3_t a);
    vec3_t o;
    longint unsigned len2, s, mag, q;
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += longint'(a[i] * a[i]);
    o = '{0, 0, 0};
    if (len2 == 0) return o;
    s = sqrt_u64(len2 << 16);
    for (int i = 0; i < 3; i++) begin
      mag = a[i] < 0 ? -a[i] : a[i];
      q = ((mag << 22) + s / 2) / s;
      if (q > UNIT_Q14) q = UNIT_Q14;
      o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    return o;
  endfunction

  function automatic longint dot_vec(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint unsigned unit_clamp(longint d);
    longint unsigned q;
    if (d <= 0) return 0;
    q = (longint'(d) + 8192) >> 14;
    return q > UNIT_Q14 ? UNIT_Q14 : q;
  endfunction

  // c^e with c in Q1.14, e in Q8.8, result Q0.16
  function automatic longint unsigned spec_pow(longint unsigned c, longint unsigned e);
    longint unsigned m, k, f, lq, p, ip, fp, r, t;
    if (e == 0) return 65536;
    if (c == 0) return 0;
    m = c << 16;
    k = 0;
    f = 0;
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      k++;
    end
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      f <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        f |= 1;
      end
    end
    lq = (k << 16) - f;
    p = (lq * e + 128) >> 8;
    ip = p >> 16;
    fp = p & 64'hFFFF;
    if (ip >= 16) return 0;
    r = 64'd1 << 30;
    t = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      t = sqrt_u64(t << 30);
      if ((fp >> (16 - i)) & 1) r = (r * t + (64'd1 << 29)) >> 30;
    end
    r >>= ip;
    r = (r + 8192) >> 14;
    return r > 65536 ? 65536 : r;
  endfunction

  // expected color for one fragment under the current settings
  function automatic shade_t shade_fragment(frag_t fr);
    vec3_t nraw, n, l, vraw, v, hraw, h;
    longint unsigned d, spec, kd, scale, alb, md, ms, lc, base, dp, sp, lit, total, q;
    logic [15:0] albs [3];
    logic [15:0] nrm [3];
    logic [19:0] ps [3];
    logic [15:0] outs [3];
    shade_t res;
    albs = '{fr.alb_r, fr.alb_g, fr.alb_b};
    nrm = '{fr.nx, fr.ny, fr.nz};
    ps = '{fr.px, fr.py, fr.pz};
    spec = 0;
    for (int i = 0; i < 3; i++) begin
      nraw[i] = longint'($signed(nrm[i]));
      l[i] = longint'($signed(light_dir_q[16*i +: 16]));
      vraw[i] = longint'($signed(cam_pos_q[20*i +: 20])) - longint'($signed(ps[i]));
    end
    n = unit_vec(nraw);
    d = unit_clamp(dot_vec(n, l));
    if (mat_spec_q != 0 && d > 0) begin
      v = unit_vec(vraw);
      if (dot_vec(n, v) > 0) begin
        for (int i = 0; i < 3; i++) hraw[i] = l[i] + v[i];
        h = unit_vec(hraw);
        spec = spec_pow(unit_clamp(dot_vec(n, h)), shin_q);
      end
    end
    kd = ((65536 - longint'(amb_q)) * d + 8192) >> 14;
    scale = longint'(inten_q) * longint'(fr.vis);
    for (int i = 0; i < 3; i++) begin
      alb = albs[i];
      md = mat_diff_q[16*i +: 16];
      ms = mat_spec_q[16*i +: 16];
      lc = light_col_q[16*i +: 16];
      base = (alb * md + 32768) >> 16;
      dp = (base * kd + 32768) >> 16;
      sp = (spec * ms + 32768) >> 16;
      lit = (lc * (dp + sp) + 32768) >> 16;
      total = ((base * amb_q) << 11) + lit * scale;
      q = (total + (64'd1 << 30)) >> 31;
      outs[i] = q > 64'hFFFF ? 16'hFFFF : q[15:0];
    end
    res.r = outs[0];
    res.g = outs[1];
    res.b = outs[2];
    return res;
  endfunction

  task automatic report(string what, logic [15:0] exp_v, logic [15:0] got_v);
    errors++;
    $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
  endtask

  // capture each accepted request and queue its expected color
  always @(posedge clk) begin
    frag_t fr;
    shade_t s;
    if (!rst && start && !busy) begin
      fr = '{albedo_r, albedo_g, albedo_b, normal_x, normal_y, normal_z,
             pos_x, pos_y, pos_z, visibility};
      if (typed_on) s = '{16'd0, 16'd0, 16'd0};
      else s = shade_fragment(fr);
      pending_shades.push_back(s);
    end
  end

  // compare each strobed color with the oldest expectation
  always @(posedge clk) begin
    shade_t s;
    if (!rst && done) begin
      if (pending_shades.size() == 0) begin
        report("unexpected result shade_r", 16'd0, shade_r);
      end else begin
        s = pending_shades.pop_front();
        if (shade_r !== s.r) report("shade_r", s.r, shade_r);
        if (shade_g !== s.g) report("shade_g", s.g, shade_g);
        if (shade_b !== s.b) report("shade_b", s.b, shade_b);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [59:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LIGHT_DIR:   light_dir_q = val[47:0];
      REG_LIGHT_COLOR: light_col_q = val[47:0];
      REG_MAT_DIFF:    mat_diff_q = val[47:0];
      REG_MAT_SPEC:    mat_spec_q = val[47:0];
      REG_CAM_POS:     cam_pos_q = val;
      REG_SHININESS:   shin_q = val[15:0];
      REG_AMBIENT:     amb_q = val[15:0];
      default:         inten_q = val[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic [47:0] ld, logic [47:0] lc, logic [47:0] md,
                           logic [47:0] ms, logic [59:0] cam, logic [15:0] shin,
                           logic [15:0] amb, logic [15:0] inten);
    write_reg(REG_LIGHT_DIR, 60'(ld));
    write_reg(REG_LIGHT_COLOR, 60'(lc));
    write_reg(REG_MAT_DIFF, 60'(md));
    write_reg(REG_MAT_SPEC, 60'(ms));
    write_reg(REG_CAM_POS, cam);
    write_reg(REG_SHININESS, 60'(shin));
    write_reg(REG_AMBIENT, 60'(amb));
    write_reg(REG_INTENSITY, 60'(inten));
    cfg_we <= 1'b0;
  endtask

  // present one request after an optional gap, hold until accepted
  task automatic send_frag(frag_t fr, int gap, logic typed);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    typed_on <= typed;
    albedo_r <= fr.alb_r;
    albedo_g <= fr.alb_g;
    albedo_b <= fr.alb_b;
    normal_x <= fr.nx;
    normal_y <= fr.ny;
    normal_z <= fr.nz;
    pos_x <= fr.px;
    pos_y <= fr.py;
    pos_z <= fr.pz;
    visibility <= fr.vis;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_shades.size() != 0) @(posedge clk);
  endtask

  function automatic frag_t rand_frag();
    frag_t fr;
    fr.alb_r = $urandom;
    fr.alb_g = $urandom;
    fr.alb_b = $urandom;
    fr.nx = $urandom;
    fr.ny = $urandom;
    fr.nz = $urandom;
    // keep most fragments near the camera so the view vector varies
    if ($urandom_range(0, 3) == 0) begin
      fr.px = $urandom;
      fr.py = $urandom;
      fr.pz = $urandom;
    end else begin
      fr.px = 20'($signed(cam_pos_q[19:0]) + $signed(20'($urandom_range(0, 8191)) - 20'sd4096));
      fr.py = 20'($signed(cam_pos_q[39:20]) + $signed(20'($urandom_range(0, 8191)) - 20'sd4096));
      fr.pz = 20'($signed(cam_pos_q[59:40]) + $signed(20'($urandom_range(0, 8191)) - 20'sd4096));
    end
    fr.vis = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    return fr;
  endfunction

  function automatic logic [47:0] rand_light_dir();
    vec3_t a, u;
    logic [47:0] w;
    for (int i = 0; i < 3; i++) a[i] = longint'($signed(16'($urandom)));
    u = unit_vec(a);
    for (int i = 0; i < 3; i++) w[16*i +: 16] = 16'(u[i]);
    if ($urandom_range(0, 5) == 0) w = {16'($urandom), 32'($urandom)};
    return w;
  endfunction

  frag_t dir_rows [8] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 20'd0, 20'd0, 20'd0, 16'd0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd8192, 20'd0, 20'd0, 20'd0, 16'd32768},
    '{16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF,
      20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'hFFFF},
    '{16'h1234, 16'hABCD, 16'h5555, 16'h8000, 16'h8000, 16'h8000,
      20'h80000, 20'h80000, 20'h80000, 16'd32768},
    '{16'hC000, 16'hC000, 16'hC000, 16'sd0, 16'sd0, 16'sd0, 20'd100, 20'd200, 20'd300, 16'd32768},
    '{16'h8000, 16'h8000, 16'h8000, 16'sd0, 16'sd0, -16'sd8192, 20'd0, 20'd0, 20'd0, 16'd32768},
    '{16'h4000, 16'h9000, 16'hE000, 16'sd100, -16'sd200, 16'sd8000,
      20'd1024, -20'sd2048, 20'd4096, 16'd16384},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd8192, 20'd0, 20'd0, 20'd10240, 16'd32768}
  };

  initial begin
    int gap_mode;
    light_dir_q = '0;
    light_col_q = '0;
    mat_diff_q = '0;
    mat_spec_q = '0;
    cam_pos_q = '0;
    shin_q = 16'd256;
    amb_q = '0;
    inten_q = 16'd4096;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no diffuse, no light, every color is black
    foreach (dir_rows[i]) send_frag(dir_rows[i], 0, 1'b1);
    drain();
    typed_on <= 1'b0;

    // light straight down z, camera ten units up
    write_all({16'sd16384, 16'sd0, 16'sd0}, 48'hFFFF_FFFF_FFFF, 48'hFFFF_C000_8000,
              48'h8000_8000_8000, {20'd10240, 20'd0, 20'd0}, 16'd8192, 16'h1000, 16'd4096);
    foreach (dir_rows[i]) send_frag(dir_rows[i], i % 2, 1'b0);
    drain();

    // oversized light, shininess zero, everything at the top
    write_all(48'h7FFF_7FFF_7FFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              48'hFFFF_FFFF_FFFF, 60'hFFF_FFFF_FFFF_FFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    foreach (dir_rows[i]) send_frag(dir_rows[i], 0, 1'b0);
    drain();

    // random settings per phase after an all-zero first phase, random fragments
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        write_all('0, '0, '0, '0, '0, 16'd0, 16'd0, 16'd0);
      end else begin
        write_all(rand_light_dir(), {16'($urandom), 32'($urandom)},
                  {16'($urandom), 32'($urandom)},
                  ($urandom_range(0, 5) == 0) ? 48'd0 : {16'($urandom), 32'($urandom)},
                  {28'($urandom), 32'($urandom)},
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384)),
                  16'($urandom), 16'($urandom));
      end
      gap_mode = $urandom_range(0, 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_frag(rand_frag(),
                  (gap_mode == 0) ? 0 :
                  (gap_mode == 1) ? $urandom_range(0, 17) :
                  (($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0), 1'b0);
      end
      drain();
    end

    repeat (RESULT_LAT + 20) @(posedge clk);
    if (errors == 0 && pending_shades.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/bpfs_pkg.sv
hdl/bpfs_norm.sv
hdl/blinn_phong_fragment_shade.sv
sim/blinn_phong_fragment_shade_tb.sv
